// File: src/point_in_polygon_test_unit_macros.svh
// Assertion macros shared by the point-in-polygon test unit.
`ifndef POINT_IN_POLYGON_TEST_UNIT_MACROS_SVH
`define POINT_IN_POLYGON_TEST_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pip_pkg.sv
// Types and constants of the point-in-polygon test unit.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int Q_ONE        = 256;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CLOSE,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_in_word;

    typedef struct packed {
        logic             inside_res;
        logic             error;
        logic [CNT_W-1:0] vertex_total;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    localparam int VTX_W = $bits(t_vertex);

endpackage

// File: src/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: vertex memory, edge walker, crossing pipeline.
//
// The unit keeps up to MAX_VERTICES vertices in one vertex memory, loaded by append words
// and emptied by a clear word; a query word tests its point by ray crossing over the stored
// edges and returns inside when an odd number of edges count. Every input word gives one
// result word. One word is worked on at a time: clear, append, an unused command and a
// query with two or fewer vertices go from idle straight to the result state; a query over
// more vertices walks the vertex memory, which delivers one vertex per cycle to the edge
// walker, then sends the closing edge and drains a three-stage compare pipeline (diff, multiply,
// compare). A finished result waits in the output register while the next word is accepted.
// The vertex memory is not cleared; only entries below the vertex count are ever read.
`include "point_in_polygon_test_unit_macros.svh"

module point_in_polygon_test_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pip_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pip_pkg::t_out_word  o_out_word
);

    localparam int CW = pip_pkg::CNT_W;
    localparam int AW = pip_pkg::ADDR_W;
    localparam int DW = pip_pkg::DIFF_W;
    localparam int PW = pip_pkg::PROD_W;
    localparam int XW = pip_pkg::COORD_W;

    pip_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_addr, n_addr;
    pip_pkg::t_out_word r_res, n_res;
    pip_pkg::t_out_word r_out_word;
    logic               r_out_valid;
    logic               r_parity, n_parity;
    logic               r_rd_vld, r_rd_first;
    logic signed [XW-1:0] r_qx, r_qy;
    pip_pkg::t_vertex   r_first, r_prev;

    // edge pipeline
    logic               r_e0_vld, r_e1_vld, r_e2_vld;
    pip_pkg::t_vertex   r_e0_p1, r_e0_p2;
    logic               r_e1_pre, r_e1_dx_small, r_e1_dy_neg;
    logic signed [DW-1:0] r_e1_a, r_e1_b, r_e1_c, r_e1_d;
    logic               r_e2_pre, r_e2_dx_small, r_e2_dy_neg;
    logic signed [PW-1:0] r_e2_lhs, r_e2_rhs;

    pip_pkg::t_cmd      cmd;
    logic               in_acc, out_free, full, few, is_query_walk;
    logic               rd_en, wr_en, e0_load;
    logic [AW-1:0]      rd_addr;
    pip_pkg::t_vertex   rd_data, wr_data, launch_p2;

    assign cmd      = pip_pkg::t_cmd'(i_in_word.command);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = r_count >= CW'(pip_pkg::MAX_VERTICES);
    assign few      = r_count <= CW'(2);
    assign is_query_walk = (cmd == pip_pkg::CMD_QUERY) && !few;
    assign wr_data  = '{x: i_in_word.point_x, y: i_in_word.point_y};

    pip_ram #(
        .WIDTH(pip_pkg::VTX_W),
        .DEPTH(pip_pkg::MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pip_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = is_query_walk ? pip_pkg::S_WALK : pip_pkg::S_RESULT;
                end
            end
            pip_pkg::S_WALK: begin
                if (r_addr == r_count && r_rd_vld) begin
                    n_state = pip_pkg::S_CLOSE;
                end
            end
            pip_pkg::S_CLOSE: begin
                n_state = pip_pkg::S_DRAIN;
            end
            pip_pkg::S_DRAIN: begin
                if (!r_e0_vld && !r_e1_vld && !r_e2_vld) begin
                    n_state = pip_pkg::S_RESULT;
                end
            end
            pip_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = pip_pkg::S_IDLE;
                end
            end
            default: n_state = pip_pkg::S_IDLE;
        endcase
    end

    // state outputs: memory control and edge launch
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = r_addr[AW-1:0];
        wr_en      = 1'b0;
        e0_load    = 1'b0;
        launch_p2  = rd_data;
        case (r_state)
            pip_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                rd_addr    = '0;
                rd_en      = in_acc && is_query_walk;
                wr_en      = in_acc && (cmd == pip_pkg::CMD_APPEND) && !full;
            end
            pip_pkg::S_WALK: begin
                rd_en   = r_addr != r_count;
                e0_load = r_rd_vld && !r_rd_first;
            end
            pip_pkg::S_CLOSE: begin
                // closing edge back to vertex 0; degenerate and never counted when closed
                e0_load   = 1'b1;
                launch_p2 = r_first;
            end
            default: ;
        endcase
    end

    // control datapath
    always_comb begin
        n_count  = r_count;
        n_addr   = r_addr;
        n_res    = r_res;
        n_parity = r_parity;
        if (r_state == pip_pkg::S_IDLE && in_acc) begin
            n_addr   = CW'(1);
            n_parity = 1'b0;
            n_res    = '{inside_res: 1'b0, error: 1'b0, vertex_total: r_count};
            case (cmd)
                pip_pkg::CMD_CLEAR: begin
                    n_count = '0;
                    n_res.vertex_total = '0;
                end
                pip_pkg::CMD_APPEND: begin
                    if (full) begin
                        n_res.error = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                        n_res.vertex_total = r_count + CW'(1);
                    end
                end
                default: ;
            endcase
        end
        if (r_state == pip_pkg::S_WALK && rd_en) begin
            n_addr = r_addr + CW'(1);
        end
        if (r_e2_vld && r_e2_pre &&
            (r_e2_dx_small || (r_e2_dy_neg ? (r_e2_lhs >= r_e2_rhs)
                                           : (r_e2_lhs <= r_e2_rhs)))) begin
            n_parity = !r_parity;
        end
        if (r_state == pip_pkg::S_DRAIN && n_state == pip_pkg::S_RESULT) begin
            n_res.inside_res = r_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pip_pkg::S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_parity    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_first  <= 1'b0;
            r_e0_vld    <= 1'b0;
            r_e1_vld    <= 1'b0;
            r_e2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_addr     <= n_addr;
            r_parity   <= n_parity;
            r_rd_vld   <= rd_en;
            r_rd_first <= r_state == pip_pkg::S_IDLE;
            r_e0_vld   <= e0_load;
            r_e1_vld   <= r_e0_vld;
            r_e2_vld   <= r_e1_vld;
            if (r_state == pip_pkg::S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == pip_pkg::S_IDLE && in_acc) begin
            r_qx <= i_in_word.point_x;
            r_qy <= i_in_word.point_y;
        end
        if (r_rd_vld) begin
            r_prev <= rd_data;
            if (r_rd_first) begin
                r_first <= rd_data;
            end
        end
        if (e0_load) begin
            r_e0_p1 <= r_prev;
            r_e0_p2 <= launch_p2;
        end
        if (r_state == pip_pkg::S_RESULT && out_free) begin
            r_out_word <= r_res;
        end
    end

    // stage 1: spans and differences
    logic signed [XW-1:0] ymin, ymax, xmax;
    logic signed [DW-1:0] dy, dx;
    logic [DW-1:0]        dy_abs, dx_abs;

    always_comb begin
        ymin   = (r_e0_p1.y < r_e0_p2.y) ? r_e0_p1.y : r_e0_p2.y;
        ymax   = (r_e0_p1.y > r_e0_p2.y) ? r_e0_p1.y : r_e0_p2.y;
        xmax   = (r_e0_p1.x > r_e0_p2.x) ? r_e0_p1.x : r_e0_p2.x;
        dy     = DW'(r_e0_p2.y) - DW'(r_e0_p1.y);
        dx     = DW'(r_e0_p2.x) - DW'(r_e0_p1.x);
        dy_abs = dy[DW-1] ? DW'(-dy) : DW'(dy);
        dx_abs = dx[DW-1] ? DW'(-dx) : DW'(dx);
    end

    always_ff @(posedge i_clk) begin
        r_e1_pre      <= (r_qy >= ymin) && (r_qy <= ymax) && (r_qx <= xmax) &&
                         (dy_abs > DW'(pip_pkg::Q_ONE));
        r_e1_dx_small <= dx_abs <= DW'(pip_pkg::Q_ONE);
        r_e1_dy_neg   <= dy[DW-1];
        r_e1_a        <= DW'(r_qx) - DW'(r_e0_p1.x);
        r_e1_b        <= dy;
        r_e1_c        <= DW'(r_qy) - DW'(r_e0_p1.y);
        r_e1_d        <= dx;
    end

    // stage 2: cross products
    always_ff @(posedge i_clk) begin
        r_e2_pre      <= r_e1_pre;
        r_e2_dx_small <= r_e1_dx_small;
        r_e2_dy_neg   <= r_e1_dy_neg;
        r_e2_lhs      <= PW'(r_e1_a) * PW'(r_e1_b);
        r_e2_rhs      <= PW'(r_e1_c) * PW'(r_e1_d);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `PIP_ASSERT_NOW(a_count_max, 1'b1, r_count <= CW'(pip_pkg::MAX_VERTICES), "vertex count overflow")
    `PIP_ASSERT_NOW(a_rd_in_range, rd_en && r_state == pip_pkg::S_WALK, r_addr < r_count, "read beyond stored vertices")
    `PIP_ASSERT_NOW(a_idle_empty, r_state == pip_pkg::S_IDLE, !r_e0_vld && !r_e1_vld && !r_e2_vld, "edge pipeline busy while idle")
    `PIP_ASSERT_NEXT(a_append_count, wr_en, r_count == $past(r_count) + CW'(1), "append did not advance count")
    `PIP_ASSERT_NOW(a_error_only, o_out_valid && o_out_word.error, !o_out_word.inside_res, "error word flagged inside")

endmodule

// File: src/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: bench/tb_point_in_polygon_test_unit.sv
// Testbench of the point-in-polygon test unit: directed and random streams checked by a mirror.
module tb_point_in_polygon_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int COORD_MIN    = -(1 << (pip_pkg::COORD_W - 1));
    localparam int COORD_MAX    = (1 << (pip_pkg::COORD_W - 1)) - 1;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_SLACK  = pip_pkg::MAX_VERTICES + 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 320;
    localparam int MAX_SHOWN    = 10;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    pip_pkg::t_in_word  i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    pip_pkg::t_out_word o_out_word;

    // mirror of the vertex store
    logic signed [pip_pkg::COORD_W-1:0] poly_x [pip_pkg::MAX_VERTICES];
    logic signed [pip_pkg::COORD_W-1:0] poly_y [pip_pkg::MAX_VERTICES];
    int        poly_count = 0;

    pip_pkg::t_out_word pending_results [$];
    int        mismatches   = 0;
    int        cycle_count  = 0;
    int        items_sent   = 0;
    bit        quiet_phase  = 1'b0;
    int        hold_request = 0;
    int        hold_left    = 0;
    int        out_wait     = 0;

    always #10 i_clk = ~i_clk;

    point_in_polygon_test_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    function automatic bit edge_crosses(longint x1, longint y1, longint x2, longint y2,
                                        longint qx, longint qy);
        longint ymin, ymax, xmax, dx, dy;
        ymin = (y1 < y2) ? y1 : y2;
        ymax = (y1 > y2) ? y1 : y2;
        xmax = (x1 > x2) ? x1 : x2;
        if (qy < ymin || qy > ymax || qx > xmax) return 1'b0;
        dy = y2 - y1;
        dx = x2 - x1;
        if (((dy < 0) ? -dy : dy) <= pip_pkg::Q_ONE) return 1'b0;
        if (((dx < 0) ? -dx : dx) <= pip_pkg::Q_ONE) return 1'b1;
        // compare against the crossing point without dividing by dy
        if (dy > 0) return (qx - x1) * dy <= (qy - y1) * dx;
        return (qx - x1) * dy >= (qy - y1) * dx;
    endfunction

    function automatic bit point_inside(longint qx, longint qy);
        int edges, nxt, crossings;
        bit closed;
        if (poly_count <= 2) return 1'b0;
        closed = poly_x[0] == poly_x[poly_count-1] && poly_y[0] == poly_y[poly_count-1];
        edges = closed ? poly_count - 1 : poly_count;
        crossings = 0;
        for (int i = 0; i < edges; i++) begin
            nxt = (i + 1 == poly_count) ? 0 : i + 1;
            if (edge_crosses(poly_x[i], poly_y[i], poly_x[nxt], poly_y[nxt], qx, qy))
                crossings++;
        end
        return crossings[0];
    endfunction

    function automatic pip_pkg::t_out_word apply_word(pip_pkg::t_in_word w);
        pip_pkg::t_out_word r;
        r = '0;
        case (w.command)
            pip_pkg::CMD_CLEAR: poly_count = 0;
            pip_pkg::CMD_APPEND: begin
                if (poly_count >= pip_pkg::MAX_VERTICES) begin
                    r.error = 1'b1;
                end else begin
                    poly_x[poly_count] = w.point_x;
                    poly_y[poly_count] = w.point_y;
                    poly_count++;
                end
            end
            pip_pkg::CMD_QUERY: r.inside_res = point_inside(w.point_x, w.point_y);
            default: ;
        endcase
        r.vertex_total = pip_pkg::CNT_W'(poly_count);
        return r;
    endfunction

    function automatic int clamp_coord(longint v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return int'(v);
    endfunction

    function automatic int coord_near(int c, int span);
        return clamp_coord(longint'(c) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic int any_coord();
        return clamp_coord(longint'($urandom_range(0, 24'hFFFFFF)) + COORD_MIN);
    endfunction

    function automatic int grid_coord(int c, int step);
        return clamp_coord(longint'(c) + longint'(step) * (int'($urandom_range(0, 20)) - 10));
    endfunction

    // receiver: per-word random stall, plus a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) out_wait = quiet_phase ? 0 : $urandom_range(0, 19);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        pip_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result word inside=%0d error=%0d total=%0d",
                             o_out_word.inside_res, o_out_word.error, o_out_word.vertex_total);
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.inside_res !== want.inside_res || o_out_word.error !== want.error
                        || o_out_word.vertex_total !== want.vertex_total) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: expected inside=%0d error=%0d total=%0d, got %s",
                                 want.inside_res, want.error, want.vertex_total,
                                 $sformatf("inside=%0d error=%0d total=%0d",
                                           o_out_word.inside_res, o_out_word.error,
                                           o_out_word.vertex_total));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL point_in_polygon_test_unit");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input int x, input int y);
        pip_pkg::t_in_word w;
        int gap;
        w.command = cmd;
        w.point_x = x[pip_pkg::COORD_W-1:0];
        w.point_y = y[pip_pkg::COORD_W-1:0];
        gap = quiet_phase ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_word(w));
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_few_vertices();
        send_word(pip_pkg::CMD_QUERY, 0, 0);
        send_word(pip_pkg::CMD_APPEND, 0, 0);
        send_word(pip_pkg::CMD_QUERY, 0, 0);
        send_word(pip_pkg::CMD_APPEND, 2560, 0);
        send_word(pip_pkg::CMD_QUERY, 1280, 0);
        send_word(CMD_UNUSED, -1, -1);
        send_word(pip_pkg::CMD_CLEAR, 0, 0);
        wait_drained();
    endtask

    task automatic test_square_and_closing();
        send_word(pip_pkg::CMD_APPEND, -2560, -2560);
        send_word(pip_pkg::CMD_APPEND, 2560, -2560);
        send_word(pip_pkg::CMD_APPEND, 2560, 2560);
        send_word(pip_pkg::CMD_APPEND, -2560, 2560);
        send_word(pip_pkg::CMD_QUERY, 0, 0);
        send_word(pip_pkg::CMD_QUERY, 5000, 0);
        send_word(pip_pkg::CMD_QUERY, -2560, 0);
        send_word(pip_pkg::CMD_QUERY, 0, 2560);
        // repeat the first vertex so the list counts as closed
        send_word(pip_pkg::CMD_APPEND, -2560, -2560);
        send_word(pip_pkg::CMD_QUERY, 0, 0);
        send_word(pip_pkg::CMD_CLEAR, 0, 0);
        // slanted quadrilateral with a short edge: exercises both signs of dy and the short-edge rule
        send_word(pip_pkg::CMD_APPEND, 0, 0);
        send_word(pip_pkg::CMD_APPEND, 10000, 3000);
        send_word(pip_pkg::CMD_APPEND, 2000, 9000);
        send_word(pip_pkg::CMD_APPEND, 2200, 9200);
        send_word(pip_pkg::CMD_QUERY, 3000, 3000);
        send_word(pip_pkg::CMD_QUERY, 7000, 6000);
        wait_drained();
    endtask

    task automatic test_coordinate_extremes();
        send_word(pip_pkg::CMD_CLEAR, 0, 0);
        send_word(pip_pkg::CMD_APPEND, COORD_MIN, COORD_MIN);
        send_word(pip_pkg::CMD_APPEND, COORD_MAX, COORD_MIN);
        send_word(pip_pkg::CMD_APPEND, COORD_MAX, COORD_MAX);
        send_word(pip_pkg::CMD_APPEND, COORD_MIN, COORD_MAX);
        send_word(pip_pkg::CMD_QUERY, 0, 0);
        send_word(pip_pkg::CMD_QUERY, COORD_MIN, COORD_MIN);
        send_word(pip_pkg::CMD_QUERY, COORD_MAX, COORD_MAX);
        send_word(pip_pkg::CMD_QUERY, COORD_MAX, 0);
        wait_drained();
    endtask

    task automatic test_full_store();
        send_word(pip_pkg::CMD_CLEAR, 0, 0);
        for (int i = 0; i < pip_pkg::MAX_VERTICES; i++)
            send_word(pip_pkg::CMD_APPEND, coord_near(0, 40000), coord_near(0, 40000));
        send_word(pip_pkg::CMD_APPEND, 123, 456);
        send_word(pip_pkg::CMD_QUERY, 0, 0);
        send_word(pip_pkg::CMD_QUERY, coord_near(0, 20000), coord_near(0, 20000));
        send_word(pip_pkg::CMD_CLEAR, 0, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        quiet_phase = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 6; i++)
            send_word(pip_pkg::CMD_APPEND, coord_near(0, 5000), coord_near(0, 5000));
        for (int i = 0; i < 6; i++)
            send_word(pip_pkg::CMD_QUERY, coord_near(0, 5000), coord_near(0, 5000));
        quiet_phase = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_polygons();
        int start, n, cx, cy, step, span, queries, pick;
        int vx [$];
        int vy [$];
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                send_word(pip_pkg::CMD_CLEAR, any_coord(), any_coord());
                vx.delete();
                vy.delete();
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 66)
                                                 : $urandom_range(3, 10);
                cx = coord_near(0, 1 << 22);
                cy = coord_near(0, 1 << 22);
                case ($urandom_range(0, 6))
                    0: step = 1;
                    1: step = 128;
                    2: step = pip_pkg::Q_ONE;
                    3: step = pip_pkg::Q_ONE + 1;
                    4: step = 1000;
                    5: step = 65536;
                    default: step = 0;
                endcase
                span = ($urandom_range(0, 1) == 0) ? 4096 : (1 << 20);
                for (int i = 0; i < n; i++) begin
                    // snap to a grid when a step is chosen, so short edges come up often
                    if (step != 0) begin
                        vx.push_back(grid_coord(cx, step));
                        vy.push_back(grid_coord(cy, step));
                    end else begin
                        vx.push_back(coord_near(cx, span));
                        vy.push_back(coord_near(cy, span));
                    end
                    if (i == n - 1 && n > 3 && $urandom_range(0, 2) == 0) begin
                        vx[i] = vx[0];
                        vy[i] = vy[0];
                    end
                    send_word(pip_pkg::CMD_APPEND, vx[i], vy[i]);
                end
                queries = $urandom_range(3, 8);
                for (int q = 0; q < queries; q++) begin
                    pick = $urandom_range(0, vx.size() - 1);
                    case ($urandom_range(0, 3))
                        0: send_word(pip_pkg::CMD_QUERY, vx[pick], vy[pick]);
                        1: send_word(pip_pkg::CMD_QUERY, coord_near(vx[pick], span), vy[pick]);
                        default: begin
                            if (step != 0)
                                send_word(pip_pkg::CMD_QUERY, coord_near(cx, step * 10),
                                          coord_near(cy, step * 10));
                            else
                                send_word(pip_pkg::CMD_QUERY, coord_near(cx, span),
                                          coord_near(cy, span));
                        end
                    endcase
                end
            end else begin
                for (int i = 0; i < 4; i++)
                    send_word(2'($urandom_range(0, 3)), any_coord(), any_coord());
            end
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        quiet_phase = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_few_vertices();
        test_square_and_closing();
        test_coordinate_extremes();
        test_full_store();
        test_backpressure();
        test_random_polygons();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS point_in_polygon_test_unit");
        end else begin
            $display("FAIL point_in_polygon_test_unit");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/pip_pkg.sv
src/pip_ram.sv
src/point_in_polygon_test_unit.sv
bench/tb_point_in_polygon_test_unit.sv
